### rtl/sfft_pkg.sv
`default_nettype none
package sfft_pkg;

  localparam int MAX_LOG_SLOTS = 10;
  localparam int SLOT_DEPTH    = 1024;
  localparam int SLOT_AW       = 10;
  localparam int TW_W          = 32;
  localparam int QCOS_LAST     = 1024;
  localparam int ANG_W         = 12;
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } stat_t;

  typedef enum logic {
    REG_LOG_SIZE = 1'b0,
    REG_INVERSE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_BR_RI,
    ST_BR_RJ,
    ST_BR_WI,
    ST_BR_WJ,
    ST_BF_RA,
    ST_BF_RB,
    ST_BF_CAP,
    ST_BF_MUL,
    ST_BF_WA,
    ST_BF_WB,
    ST_SC_R,
    ST_SC_W,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    logic       load;
    logic       inv;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
  } bfly_ctl_t;

  typedef logic signed [TW_W-1:0] qcos_tbl_t [0:QCOS_LAST];

  // quarter-wave cosine in Q1.30 from a Q61 Taylor series, evaluated at elaboration
  function automatic qcos_tbl_t build_qcos();
    qcos_tbl_t          t;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        ku;
    logic [127:0]       pr;
    logic signed [63:0] acc;
    logic [63:0]        accu;
    for (int k = 0; k <= QCOS_LAST; k++) begin
      ku   = 64'(k);
      x    = ku * (PI_Q61 >> 11) + ((ku * (PI_Q61 & 64'h7FF)) >> 11);
      term = 64'd1 << 61;
      acc  = signed'(term);
      for (int n = 1; n <= 32; n++) begin
        pr   = {64'd0, term} * {64'd0, x};
        term = pr[124:61] / 64'(n);
        if ((n & 3) == 2) begin
          acc = acc - signed'(term);
        end else if ((n & 3) == 0) begin
          acc = acc + signed'(term);
        end
      end
      if (acc < 0) begin
        acc = 64'sd0;
      end
      accu = unsigned'(acc) + (64'd1 << 30);
      t[k] = signed'(32'(accu >> 31));
    end
    return t;
  endfunction

  function automatic logic [SLOT_AW-1:0] bitrev10(input logic [SLOT_AW-1:0] v);
    logic [SLOT_AW-1:0] r;
    for (int b = 0; b < SLOT_AW; b++) begin
      r[b] = v[SLOT_AW-1-b];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/sfft_ram.sv
`default_nettype none
module sfft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/sfft_twiddle.sv
`default_nettype none
module sfft_twiddle
  import sfft_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic [ANG_W-1:0]        k_i,
  output logic signed [TW_W-1:0]       val_o
);

  localparam qcos_tbl_t QCOS = build_qcos();

  logic [10:0]            idx;
  logic                   neg;
  logic signed [TW_W-1:0] tbl_r;
  logic                   neg_r;

  // quadrant folding onto the quarter-wave table
  always_comb begin
    priority if (k_i <= 12'd1024) begin
      idx = 11'(k_i);
      neg = 1'b0;
    end else if (k_i <= 12'd2048) begin
      idx = 11'(12'd2048 - k_i);
      neg = 1'b1;
    end else if (k_i < 12'd3072) begin
      idx = 11'(k_i - 12'd2048);
      neg = 1'b1;
    end else begin
      idx = 11'(12'd0 - k_i);
      neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tbl_r <= QCOS[idx];
    neg_r <= neg;
  end

  assign val_o = neg_r ? -tbl_r : tbl_r;

endmodule
`default_nettype wire

### rtl/sfft_bfly.sv
`default_nettype none
module sfft_bfly
  import sfft_pkg::*;
#(
  parameter int DW = 32
) (
  input  wire logic                   clk,
  input  wire bfly_ctl_t              ctl,
  input  wire logic [2*DW-1:0]        a_i,
  input  wire logic [2*DW-1:0]        b_i,
  input  wire logic signed [TW_W-1:0] cos_i,
  input  wire logic signed [TW_W-1:0] sin_i,
  output logic [2*DW-1:0]             a_o,
  output logic [2*DW-1:0]             b_o,
  output logic                        sat_o
);

  localparam int EW = DW + 4;
  localparam int PW = DW + TW_W;
  localparam int AW = DW + 33;
  localparam int VW = DW + 3;
  localparam logic signed [AW-1:0] RND = AW'(1) << 29;

  function automatic logic [DW:0] sat_dw(input logic signed [EW-1:0] x);
    logic [EW-DW:0] hi;
    hi = x[EW-1:DW-1];
    if (&hi || !(|hi)) begin
      return {1'b0, x[DW-1:0]};
    end else if (x[EW-1]) begin
      return {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  logic signed [DW-1:0] a_re_in, a_im_in, b_re_in, b_im_in;
  logic signed [DW-1:0] ar_r, ai_r, br_r, bi_r, vr_r, vi_r;
  logic                 dsat_r;
  logic [DW:0]          d_re, d_im;
  logic signed [DW-1:0] opx;
  logic signed [TW_W-1:0] opy;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] accr_r, acci_r, pext;
  logic signed [VW-1:0] v_re, v_im;
  logic signed [EW-1:0] sa_re, sa_im, sb_re, sb_im;
  logic [DW:0]          ra_re, ra_im, rb_re, rb_im;

  assign a_re_in = a_i[2*DW-1:DW];
  assign a_im_in = a_i[DW-1:0];
  assign b_re_in = b_i[2*DW-1:DW];
  assign b_im_in = b_i[DW-1:0];

  assign d_re = sat_dw(EW'(a_re_in) - EW'(b_re_in));
  assign d_im = sat_dw(EW'(a_im_in) - EW'(b_im_in));

  always_comb begin
    unique case (ctl.mul_sel)
      2'd0:    begin opx = vr_r; opy = cos_i; end
      2'd1:    begin opx = vi_r; opy = sin_i; end
      2'd2:    begin opx = vr_r; opy = sin_i; end
      default: begin opx = vi_r; opy = cos_i; end
    endcase
  end

  assign pext = AW'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ar_r <= a_re_in;
      ai_r <= a_im_in;
      br_r <= b_re_in;
      bi_r <= b_im_in;
      // the inverse rotates the saturated difference
      vr_r   <= ctl.inv ? signed'(d_re[DW-1:0]) : b_re_in;
      vi_r   <= ctl.inv ? signed'(d_im[DW-1:0]) : b_im_in;
      dsat_r <= ctl.inv & (d_re[DW] | d_im[DW]);
    end
    if (ctl.mul_en) begin
      prod_r <= PW'(opx) * PW'(opy);
    end
    if (ctl.acc_en) begin
      unique case (ctl.acc_sel)
        2'd0:    accr_r <= pext;
        2'd1:    accr_r <= accr_r - pext;
        2'd2:    acci_r <= pext;
        default: acci_r <= acci_r + pext;
      endcase
    end
  end

  // round half up from Q46 to Q16
  assign v_re = VW'((accr_r + RND) >>> 30);
  assign v_im = VW'((acci_r + RND) >>> 30);

  always_comb begin
    if (ctl.inv) begin
      sa_re = EW'(ar_r) + EW'(br_r);
      sa_im = EW'(ai_r) + EW'(bi_r);
      sb_re = EW'(v_re);
      sb_im = EW'(v_im);
    end else begin
      sa_re = EW'(ar_r) + EW'(v_re);
      sa_im = EW'(ai_r) + EW'(v_im);
      sb_re = EW'(ar_r) - EW'(v_re);
      sb_im = EW'(ai_r) - EW'(v_im);
    end
  end

  assign ra_re = sat_dw(sa_re);
  assign ra_im = sat_dw(sa_im);
  assign rb_re = sat_dw(sb_re);
  assign rb_im = sat_dw(sb_im);

  assign a_o   = {ra_re[DW-1:0], ra_im[DW-1:0]};
  assign b_o   = {rb_re[DW-1:0], rb_im[DW-1:0]};
  assign sat_o = ra_re[DW] | ra_im[DW] | rb_re[DW] | rb_im[DW] | (ctl.inv & dsat_r);

endmodule
`default_nettype wire

### rtl/ckks_special_fft.sv
// Special FFT engine for CKKS slot vectors, holding up to 1024 complex Q16.16 samples in one
// single-port-read sample memory. A load word writes its slot when in range and answers in
// the cycle after acceptance, as do a refused index and a NOP word; loads can follow back
// to back while answers are taken. A read word answers via ST_RD_WAIT from the registered
// memory data. A run word transforms the first S = 2^L slots in place: the forward pass is
// a bit-reverse sweep swapping bit-reversed pairs, followed by L*S/2 butterflies; the
// inverse does the butterflies first, then the bit-reverse sweep, then a scaling sweep
// dividing each slot by S. The butterfly cost is set by the one memory read port (two
// reads, two writes) and the single shared 32x32 multiplier taking the four twiddle products
// in turn. Status is 1 for an index of S or more, 2 if any value saturated during the run.
`default_nettype none
module ckks_special_fft
  import sfft_pkg::*;
#(
  parameter int LOG_RING_DEGREE = 11,
  parameter int DATA_WIDTH      = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [9:0]         in_slot_index,
  input  wire logic signed [31:0] in_sample_re,
  input  wire logic signed [31:0] in_sample_im,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_result_re,
  output logic signed [31:0]      out_result_im,
  output logic [1:0]              out_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [3:0]         cfg_data
);

  localparam int DW     = DATA_WIDTH;
  localparam int MAX_LG = (LOG_RING_DEGREE - 1 < MAX_LOG_SLOTS) ? LOG_RING_DEGREE - 1
                                                                : MAX_LOG_SLOTS;

  function automatic logic signed [DW-1:0] sat_in(input logic signed [31:0] x);
    logic [32-DW:0] hi;
    hi = x[31:DW-1];
    if (&hi || !(|hi)) begin
      return x[DW-1:0];
    end else if (x[31]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  logic [3:0] log_size_r;
  logic       inverse_mode_r;
  logic [3:0] lg_eff;

  fsm_t         st_r, st_nxt;
  logic [3:0]   lg_r, lg_nxt, stg_r, stg_nxt;
  logic         inv_r, inv_nxt;
  logic [10:0]  idx_r, idx_nxt;
  logic [11:0]  p_r, p_nxt;
  logic [2:0]   mc_r, mc_nxt;
  logic         run_sat_r, run_sat_nxt;
  logic [2*DW-1:0] hold_r, hold_nxt;
  logic signed [TW_W-1:0] c_r, s_r, tw_val;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_re_r, out_re_nxt, out_im_r, out_im_nxt;
  stat_t              out_stat_r, out_stat_nxt;

  logic                 ram_we;
  logic [SLOT_AW-1:0]   ram_waddr, ram_raddr;
  logic [2*DW-1:0]      ram_wdata, ram_rdata;

  bfly_ctl_t        bctl;
  logic [2*DW-1:0]  bf_a, bf_b;
  logic             bf_sat;

  logic               in_rng_ok;
  logic [SLOT_AW-1:0] cur_i, cur_j, bf_h, bf_hm1, bf_j, addr_a, addr_b;
  logic [10:0]        n_m1, hn_m1;
  logic [11:0]        k_f, k_dir, tw_k, p5, lenq_m1;
  logic signed [DW-1:0] rd_re, rd_im, ld_re, ld_im;
  logic signed [DW:0]   sc_re, sc_im;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_size_r     <= 4'd10;
      inverse_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOG_SIZE: log_size_r     <= cfg_data;
        REG_INVERSE:  inverse_mode_r <= cfg_data[0];
      endcase
    end
  end

  assign lg_eff    = (log_size_r > 4'(MAX_LG)) ? 4'(MAX_LG) : log_size_r;
  assign in_rng_ok = (in_slot_index >> lg_eff) == 10'd0;
  assign in_ready  = (st_r == ST_IDLE) && (!out_valid_r || out_ready);

  // addressing for the sweeps and butterflies
  assign cur_i   = idx_r[SLOT_AW-1:0];
  assign cur_j   = bitrev10(cur_i) >> (4'd10 - lg_r);
  assign n_m1    = (11'd1 << lg_r) - 11'd1;
  assign hn_m1   = (11'd1 << (lg_r - 4'd1)) - 11'd1;
  assign bf_h    = 10'd1 << (stg_r - 4'd1);
  assign bf_hm1  = bf_h - 10'd1;
  assign bf_j    = cur_i & bf_hm1;
  assign addr_a  = ((cur_i >> (stg_r - 4'd1)) << stg_r) | bf_j;
  assign addr_b  = addr_a | bf_h;
  assign k_f     = p_r << (4'd10 - stg_r);
  assign k_dir   = inv_r ? 12'd0 - k_f : k_f;
  assign tw_k    = (st_r == ST_BF_RB) ? k_dir + 12'd3072 : k_dir;
  assign p5      = p_r + (p_r << 2);
  assign lenq_m1 = 12'((13'd1 << (stg_r + 4'd2)) - 13'd1);

  assign rd_re = ram_rdata[2*DW-1:DW];
  assign rd_im = ram_rdata[DW-1:0];
  assign ld_re = sat_in(in_sample_re);
  assign ld_im = sat_in(in_sample_im);
  // divide by size, rounding half up
  assign sc_re = ((DW+1)'(rd_re) + ((DW+1)'(1) << (lg_r - 4'd1))) >>> lg_r;
  assign sc_im = ((DW+1)'(rd_im) + ((DW+1)'(1) << (lg_r - 4'd1))) >>> lg_r;

  always_comb begin
    st_nxt        = st_r;
    lg_nxt        = lg_r;
    stg_nxt       = stg_r;
    inv_nxt       = inv_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    mc_nxt        = mc_r;
    run_sat_nxt   = run_sat_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_i;
    ram_wdata     = bf_a;
    ram_raddr     = in_slot_index;
    bctl          = '0;
    bctl.inv      = inv_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (cmd_t'(in_cmd))
            CMD_LOAD: begin
              out_valid_nxt = 1'b1;
              out_re_nxt    = '0;
              out_im_nxt    = '0;
              if (in_rng_ok) begin
                ram_we       = 1'b1;
                ram_waddr    = in_slot_index;
                ram_wdata    = {ld_re, ld_im};
                out_stat_nxt = STAT_OK;
              end else begin
                out_stat_nxt = STAT_RANGE;
              end
            end
            CMD_READ: begin
              if (in_rng_ok) begin
                st_nxt = ST_RD_WAIT;
              end else begin
                out_valid_nxt = 1'b1;
                out_re_nxt    = '0;
                out_im_nxt    = '0;
                out_stat_nxt  = STAT_RANGE;
              end
            end
            CMD_RUN: begin
              lg_nxt      = lg_eff;
              inv_nxt     = inverse_mode_r;
              run_sat_nxt = 1'b0;
              idx_nxt     = '0;
              p_nxt       = 12'd1;
              if (lg_eff == 4'd0) begin
                st_nxt = ST_DONE;
              end else if (inverse_mode_r) begin
                stg_nxt = lg_eff;
                st_nxt  = ST_BF_RA;
              end else begin
                st_nxt = ST_BR_RI;
              end
            end
            CMD_NOP: begin
              out_valid_nxt = 1'b1;
              out_re_nxt    = '0;
              out_im_nxt    = '0;
              out_stat_nxt  = STAT_OK;
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_re_nxt    = 32'(rd_re);
        out_im_nxt    = 32'(rd_im);
        out_stat_nxt  = STAT_OK;
        st_nxt        = ST_IDLE;
      end
      ST_BR_RI, ST_BR_WJ: begin
        if (st_r == ST_BR_WJ) begin
          ram_we    = 1'b1;
          ram_waddr = cur_j;
          ram_wdata = hold_r;
        end else begin
          ram_raddr = cur_i;
        end
        if (st_r == ST_BR_RI && cur_i < cur_j) begin
          st_nxt = ST_BR_RJ;
        end else if (idx_r == n_m1) begin
          idx_nxt = '0;
          if (inv_r) begin
            st_nxt = ST_SC_R;
          end else begin
            stg_nxt = 4'd1;
            p_nxt   = 12'd1;
            st_nxt  = ST_BF_RA;
          end
        end else begin
          idx_nxt = idx_r + 11'd1;
          st_nxt  = ST_BR_RI;
        end
      end
      ST_BR_RJ: begin
        ram_raddr = cur_j;
        hold_nxt  = ram_rdata;
        st_nxt    = ST_BR_WI;
      end
      ST_BR_WI: begin
        ram_we    = 1'b1;
        ram_waddr = cur_i;
        ram_wdata = ram_rdata;
        st_nxt    = ST_BR_WJ;
      end
      ST_BF_RA: begin
        ram_raddr = addr_a;
        st_nxt    = ST_BF_RB;
      end
      ST_BF_RB: begin
        ram_raddr = addr_b;
        hold_nxt  = ram_rdata;
        st_nxt    = ST_BF_CAP;
      end
      ST_BF_CAP: begin
        bctl.load = 1'b1;
        mc_nxt    = 3'd0;
        st_nxt    = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        // products issue on steps 0..3, accumulate one step behind
        bctl.mul_en  = (mc_r != 3'd4);
        bctl.mul_sel = mc_r[1:0];
        bctl.acc_en  = (mc_r != 3'd0);
        bctl.acc_sel = 2'(mc_r - 3'd1);
        if (mc_r == 3'd4) begin
          st_nxt = ST_BF_WA;
        end else begin
          mc_nxt = mc_r + 3'd1;
        end
      end
      ST_BF_WA: begin
        ram_we      = 1'b1;
        ram_waddr   = addr_a;
        ram_wdata   = bf_a;
        run_sat_nxt = run_sat_r | bf_sat;
        st_nxt      = ST_BF_WB;
      end
      ST_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = bf_b;
        st_nxt    = ST_BF_RA;
        if (idx_r == hn_m1) begin
          idx_nxt = '0;
          p_nxt   = 12'd1;
          if (inv_r) begin
            if (stg_r == 4'd1) begin
              st_nxt = ST_BR_RI;
            end else begin
              stg_nxt = stg_r - 4'd1;
            end
          end else if (stg_r == lg_r) begin
            st_nxt = ST_DONE;
          end else begin
            stg_nxt = stg_r + 4'd1;
          end
        end else begin
          idx_nxt = idx_r + 11'd1;
          p_nxt   = (bf_j == bf_hm1) ? 12'd1 : (p5 & lenq_m1);
        end
      end
      ST_SC_R: begin
        ram_raddr = cur_i;
        st_nxt    = ST_SC_W;
      end
      ST_SC_W: begin
        ram_we    = 1'b1;
        ram_waddr = cur_i;
        ram_wdata = {sc_re[DW-1:0], sc_im[DW-1:0]};
        if (idx_r == n_m1) begin
          st_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 11'd1;
          st_nxt  = ST_SC_R;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_re_nxt    = '0;
        out_im_nxt    = '0;
        out_stat_nxt  = run_sat_r ? STAT_SAT : STAT_OK;
        st_nxt        = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lg_r       <= lg_nxt;
    stg_r      <= stg_nxt;
    inv_r      <= inv_nxt;
    idx_r      <= idx_nxt;
    p_r        <= p_nxt;
    mc_r       <= mc_nxt;
    run_sat_r  <= run_sat_nxt;
    hold_r     <= hold_nxt;
    out_re_r   <= out_re_nxt;
    out_im_r   <= out_im_nxt;
    out_stat_r <= out_stat_nxt;
    if (st_r == ST_BF_RB) begin
      c_r <= tw_val;
    end
    if (st_r == ST_BF_CAP) begin
      s_r <= tw_val;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_re = out_re_r;
  assign out_result_im = out_im_r;
  assign out_status    = out_stat_r;

  sfft_ram #(
    .WIDTH (2 * DW),
    .DEPTH (SLOT_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sfft_twiddle u_twiddle (
    .clk   (clk),
    .k_i   (tw_k),
    .val_o (tw_val)
  );

  sfft_bfly #(
    .DW (DW)
  ) u_bfly (
    .clk   (clk),
    .ctl   (bctl),
    .a_i   (hold_r),
    .b_i   (ram_rdata),
    .cos_i (c_r),
    .sin_i (s_r),
    .a_o   (bf_a),
    .b_o   (bf_b),
    .sat_o (bf_sat)
  );

`ifndef ASSERT_OFF
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_READ && in_rng_ok) |-> ##2 out_valid)
    else $error("read word not answered two cycles after acceptance");

  a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) |=> (out_valid && out_status != STAT_RANGE))
    else $error("run finished without a proper result word");

  a_bf_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BF_WB) |-> (ram_we && ram_waddr == ($past(ram_waddr) | bf_h)))
    else $error("butterfly write-back pair not half a span apart");

  a_rd_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RD_WAIT) |-> !ram_we)
    else $error("memory written while a read is in flight");
`endif

endmodule
`default_nettype wire
